// File: rtl/kpsa_pkg.sv
// Package for the keypad scanner: codes, widths, reset values and the default key map.
package kpsa_pkg;

  localparam int FIFO_DEPTH_DFLT  = 64;
  localparam int MAP_ENTRIES_DFLT = 32;
  localparam int DFLT_SLOTS       = 16;

  localparam int DELAY_W   = 31;
  localparam int TCOUNT_W  = 6;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W    = 32;
  localparam int PAT_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int LEVEL_W   = 6;
  localparam int OP_W      = 2;
  localparam int EIDX_W    = 5;
  localparam int NIB_W     = 4;

  localparam logic [DELAY_W-1:0]  FIRST_DELAY_RST  = 31'd100;
  localparam logic [DELAY_W-1:0]  REPEAT_DELAY_RST = 31'd10;
  localparam logic [TCOUNT_W-1:0] TABLE_COUNT_RST  = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT  = 2'd2;

  localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_TABLE = 2'd2;

  localparam logic [NIB_W-1:0] COL_ACTIVE_HIGH = 4'h8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ARM,
    ST_SRCH,
    ST_PUSH,
    ST_DONE
  } state_t;

  function automatic logic [NIB_W-1:0] decode_row(input logic [NIB_W-1:0] raw);
    decode_row = ~(raw ^ COL_ACTIVE_HIGH);
  endfunction

  function automatic logic [CHAR_W-1:0] dflt_char(input logic [3:0] slot);
    case (slot)
      4'd0:    dflt_char = 8'h64;
      4'd1:    dflt_char = 8'h63;
      4'd2:    dflt_char = 8'h61;
      4'd3:    dflt_char = 8'h62;
      4'd4:    dflt_char = 8'h0A;
      4'd5:    dflt_char = 8'h39;
      4'd6:    dflt_char = 8'h33;
      4'd7:    dflt_char = 8'h36;
      4'd8:    dflt_char = 8'h30;
      4'd9:    dflt_char = 8'h38;
      4'd10:   dflt_char = 8'h32;
      4'd11:   dflt_char = 8'h35;
      4'd12:   dflt_char = 8'h2A;
      4'd13:   dflt_char = 8'h37;
      4'd14:   dflt_char = 8'h31;
      4'd15:   dflt_char = 8'h34;
      default: dflt_char = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/keypad_scan_autorepeat_fifo_unit.sv
// Keypad scanner top level: pattern decode, autorepeat timing, key map search, character FIFO.
// Table write, unused op and pop: accept goes to ST_DONE, which loads the output register.
// Scan: ST_CHECK; if a key is due ST_ARM, ST_SRCH, ST_PUSH; then ST_DONE. ST_SRCH reads up to
// min(table_count, MAP_ENTRIES) entries to a match, one per cycle on its single read port.
// One item at a time; in_ready drops from accept until the result is in the output register.
// Reset (synchronous, rst_n low) restores registers and default map at once via per-slot
// valid bits; FIFO contents are undefined until written, no clearing pass.
module keypad_scan_autorepeat_fifo_unit
  import kpsa_pkg::*;
#(
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DFLT,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [TIME_W-1:0]    in_now,
  input  logic [NIB_W-1:0]     in_row0_cols,
  input  logic [NIB_W-1:0]     in_row1_cols,
  input  logic [NIB_W-1:0]     in_row2_cols,
  input  logic [NIB_W-1:0]     in_row3_cols,
  input  logic [EIDX_W-1:0]    in_entry_index,
  input  logic [PAT_W-1:0]     in_entry_pattern,
  input  logic [CHAR_W-1:0]    in_entry_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_char_valid,
  output logic [CHAR_W-1:0]    out_char_out,
  output logic                 out_queued,
  output logic                 out_dropped,
  output logic [LEVEL_W-1:0]   out_fifo_level,
  output logic [PAT_W-1:0]     out_key_pattern
);

  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int MAP_AW  = $clog2(MAP_ENTRIES);
  localparam int MAP_CW  = $clog2(MAP_ENTRIES + 1);

  state_t               state_r, state_nxt;
  logic [DELAY_W-1:0]   first_delay_r, repeat_delay_r;
  logic [TCOUNT_W-1:0]  table_count_r;
  logic [PAT_W-1:0]     last_pat_r, last_pat_nxt;
  logic [TIME_W-1:0]    deadline_r, deadline_nxt;
  logic [PAT_W-1:0]     pat_r, pat_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic                 arm_first_r, arm_first_nxt;
  logic [MAP_CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [FIFO_AW-1:0]   rd_pos_r, rd_pos_nxt;
  logic [FIFO_AW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [FIFO_AW-1:0]   fill_r, fill_nxt;
  logic                 pop_hit_r, pop_hit_nxt;
  logic                 queued_r, queued_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;

  logic                 in_fire;
  logic                 map_we, map_re, fifo_we, fifo_re;
  logic [MAP_CW-1:0]    lim;
  logic                 alu_sub;
  logic [TIME_W-1:0]    alu_b, alu_sum;
  logic [PAT_W-1:0]     eff_pat;
  logic [CHAR_W-1:0]    eff_chr;

  logic [PAT_W-1:0]     map_pat_mem [MAP_ENTRIES];
  logic [CHAR_W-1:0]    map_chr_mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] map_vld_r;
  logic [PAT_W-1:0]     map_pat_q;
  logic [CHAR_W-1:0]    map_chr_q;
  logic                 map_vld_q;
  logic [MAP_AW-1:0]    cmp_idx_r;

  logic [CHAR_W-1:0]    fifo_mem [FIFO_DEPTH];
  logic [CHAR_W-1:0]    fifo_rd_q;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign lim = (32'(table_count_r) > MAP_ENTRIES) ? MAP_CW'(MAP_ENTRIES)
                                                  : MAP_CW'(table_count_r);

  // shared 32-bit adder: deadline check (subtract) and deadline arm (add)
  assign alu_b   = alu_sub ? deadline_r
                           : {1'b0, (arm_first_r ? first_delay_r : repeat_delay_r)};
  assign alu_sum = now_r + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);

  always_comb begin
    if (map_vld_q) begin
      eff_pat = map_pat_q;
      eff_chr = map_chr_q;
    end else if (32'(cmp_idx_r) < DFLT_SLOTS) begin
      eff_pat = PAT_W'(1) << cmp_idx_r[3:0];
      eff_chr = dflt_char(cmp_idx_r[3:0]);
    end else begin
      eff_pat = '0;
      eff_chr = '0;
    end
  end

  assign map_we  = in_fire && (in_operation == OP_TABLE) &&
                   (32'(in_entry_index) < MAP_ENTRIES);
  assign fifo_re = in_fire && (in_operation == OP_POP) && (fill_r != '0);

  always_comb begin
    state_nxt     = state_r;
    last_pat_nxt  = last_pat_r;
    deadline_nxt  = deadline_r;
    pat_nxt       = pat_r;
    now_nxt       = now_r;
    arm_first_nxt = arm_first_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_v_nxt     = cmp_v_r;
    ch_nxt        = ch_r;
    rd_pos_nxt    = rd_pos_r;
    wr_pos_nxt    = wr_pos_r;
    fill_nxt      = fill_r;
    pop_hit_nxt   = pop_hit_r;
    queued_nxt    = queued_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    alu_sub       = 1'b0;
    map_re        = 1'b0;
    fifo_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pop_hit_nxt = 1'b0;
          queued_nxt  = 1'b0;
          dropped_nxt = 1'b0;
          now_nxt     = in_now;
          pat_nxt     = {decode_row(in_row0_cols), decode_row(in_row1_cols),
                         decode_row(in_row2_cols), decode_row(in_row3_cols)};
          if (in_operation == OP_SCAN) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_DONE;
          end
          if (fifo_re) begin
            pop_hit_nxt = 1'b1;
            rd_pos_nxt  = (rd_pos_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_pos_r + 1'b1;
            fill_nxt    = fill_r - 1'b1;
          end
        end
      end
      ST_CHECK: begin
        last_pat_nxt = pat_r;
        alu_sub      = 1'b1;
        if (pat_r == '0) begin
          state_nxt = ST_DONE;
        end else if (pat_r != last_pat_r) begin
          arm_first_nxt = 1'b1;
          state_nxt     = ST_ARM;
        end else if (!alu_sum[TIME_W-1]) begin
          arm_first_nxt = 1'b0;
          state_nxt     = ST_ARM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ARM: begin
        deadline_nxt = alu_sum;
        rd_idx_nxt   = '0;
        cmp_v_nxt    = 1'b0;
        state_nxt    = ST_SRCH;
      end
      ST_SRCH: begin
        if (cmp_v_r && (eff_pat == pat_r)) begin
          ch_nxt    = eff_chr;
          cmp_v_nxt = 1'b0;
          state_nxt = ST_PUSH;
        end else if (rd_idx_r < lim) begin
          map_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          cmp_v_nxt  = 1'b1;
        end else begin
          ch_nxt    = '0;
          cmp_v_nxt = 1'b0;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (ch_r != '0) begin
          if (fill_r != FIFO_AW'(FIFO_DEPTH - 1)) begin
            fifo_we    = 1'b1;
            wr_pos_nxt = (wr_pos_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
            queued_nxt = 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_delay_r  <= FIRST_DELAY_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
      table_count_r  <= TABLE_COUNT_RST;
      last_pat_r     <= '0;
      deadline_r     <= '0;
      arm_first_r    <= 1'b0;
      rd_idx_r       <= '0;
      cmp_v_r        <= 1'b0;
      rd_pos_r       <= '0;
      wr_pos_r       <= '0;
      fill_r         <= '0;
      pop_hit_r      <= 1'b0;
      queued_r       <= 1'b0;
      dropped_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      map_vld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      last_pat_r  <= last_pat_nxt;
      deadline_r  <= deadline_nxt;
      arm_first_r <= arm_first_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      fill_r      <= fill_nxt;
      pop_hit_r   <= pop_hit_nxt;
      queued_r    <= queued_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_DELAY:  first_delay_r  <= cfg_wdata[DELAY_W-1:0];
          CFG_REPEAT_DELAY: repeat_delay_r <= cfg_wdata[DELAY_W-1:0];
          CFG_TABLE_COUNT:  table_count_r  <= cfg_wdata[TCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (map_we) begin
        map_vld_r[MAP_AW'(in_entry_index)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    now_r <= now_nxt;
    ch_r  <= ch_nxt;
  end

  // key map memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_pat_mem[MAP_AW'(in_entry_index)] <= in_entry_pattern;
      map_chr_mem[MAP_AW'(in_entry_index)] <= in_entry_char;
    end
    if (map_re) begin
      map_pat_q <= map_pat_mem[rd_idx_r[MAP_AW-1:0]];
      map_chr_q <= map_chr_mem[rd_idx_r[MAP_AW-1:0]];
      map_vld_q <= map_vld_r[rd_idx_r[MAP_AW-1:0]];
      cmp_idx_r <= rd_idx_r[MAP_AW-1:0];
    end
  end

  // character FIFO storage
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[wr_pos_r] <= ch_r;
    end
    if (fifo_re) begin
      fifo_rd_q <= fifo_mem[rd_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_valid  <= pop_hit_r;
      out_char_out    <= pop_hit_r ? fifo_rd_q : '0;
      out_queued      <= queued_r;
      out_dropped     <= dropped_r;
      out_fifo_level  <= LEVEL_W'(fill_r);
      out_key_pattern <= last_pat_r;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= FIFO_DEPTH - 1)
    else $error("fifo fill count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("ready while an item is in progress");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_queued && out_dropped) &&
                    !(out_char_valid && (out_queued || out_dropped)))
    else $error("conflicting result flags");

  a_push_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_we |-> (ch_r != '0) && (state_r == ST_PUSH))
    else $error("fifo write without a character");
`endif

endmodule

// File: tb/sv/tb_keypad_scan_autorepeat_fifo_unit.sv
// Keypad scanner testbench: a directed table, then random beats checked against a local model.
module tb_keypad_scan_autorepeat_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kpsa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAP_N         = MAP_ENTRIES_DFLT;
  localparam int FIFO_CAP      = FIFO_DEPTH_DFLT - 1;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 175;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 48;
  localparam int DIR_ROWS      = 25;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic [NIB_W-1:0]  row0;
    logic [NIB_W-1:0]  row1;
    logic [NIB_W-1:0]  row2;
    logic [NIB_W-1:0]  row3;
    logic [EIDX_W-1:0] slot;
    logic [PAT_W-1:0]  spat;
    logic [CHAR_W-1:0] schr;
  } key_item_t;

  typedef struct packed {
    logic               chv;
    logic [CHAR_W-1:0]  chr;
    logic               queued;
    logic               dropped;
    logic [LEVEL_W-1:0] level;
    logic [PAT_W-1:0]   keys;
  } key_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic [PAT_W-1:0]  keys;
    logic [EIDX_W-1:0] slot;
    logic [PAT_W-1:0]  spat;
    logic [CHAR_W-1:0] schr;
    logic              typed;
    key_result_t       want;
  } dir_row_t;

  localparam key_result_t QUIET = '0;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_POP,    32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b1, QUIET},
    '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 16'hFFFF, 8'hFF, 1'b1, QUIET},
    '{OP_SCAN,   32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b1, QUIET},
    '{OP_SCAN,   32'd5,         16'h0001, 5'd0,  16'h0000, 8'h00, 1'b1,
      '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1, 16'h0001}},
    '{OP_SCAN,   32'd104,       16'h0001, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd105,       16'h0001, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd115,       16'h0001, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_POP,    32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd200,       16'h8000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd201,       16'h0003, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd202,       16'h7777, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd203,       16'h8888, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd204,       16'hFFFF, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd205,       16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_TABLE,  32'd0,         16'h0000, 5'd31, 16'hFFFF, 8'hFF, 1'b0, QUIET},
    '{OP_TABLE,  32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_TABLE,  32'd0,         16'h0000, 5'd5,  16'h0001, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'd300,       16'h0001, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'hFFFF_FFF0, 16'h0002, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'h0000_0053, 16'h0002, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_SCAN,   32'h0000_0054, 16'h0002, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_POP,    32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_POP,    32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET},
    '{OP_TABLE,  32'd0,         16'h0000, 5'd16, 16'h1234, 8'h41, 1'b0, QUIET},
    '{OP_UNUSED, 32'd0,         16'h0000, 5'd0,  16'h0000, 8'h00, 1'b0, QUIET}
  };

  localparam logic [CHAR_W-1:0] KEY_CHARS [16] = '{
    "d", "c", "a", "b", 8'h0A, "9", "3", "6", "0", "8", "2", "5", "*", "7", "1", "4"
  };

  localparam logic [DELAY_W-1:0] FD_SET [PHASES] =
    '{31'd3, 31'd0, 31'h7FFF_FFFF, 31'd20, 31'd1, 31'd50};
  localparam logic [DELAY_W-1:0] RD_SET [PHASES] =
    '{31'd2, 31'd0, 31'h7FFF_FFFF, 31'd5, 31'h7FFF_FFFF, 31'd1};
  localparam logic [TCOUNT_W-1:0] TC_SET [PHASES] = '{6'd32, 6'd63, 6'd0, 6'd16, 6'd31, 6'd33};
  localparam int POP_PCT [PHASES] = '{25, 5, 40, 10, 30, 3};

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_W-1:0]     cfg_wdata        = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation     = '0;
  logic [TIME_W-1:0]    in_now           = '0;
  logic [NIB_W-1:0]     in_row0_cols     = '0;
  logic [NIB_W-1:0]     in_row1_cols     = '0;
  logic [NIB_W-1:0]     in_row2_cols     = '0;
  logic [NIB_W-1:0]     in_row3_cols     = '0;
  logic [EIDX_W-1:0]    in_entry_index   = '0;
  logic [PAT_W-1:0]     in_entry_pattern = '0;
  logic [CHAR_W-1:0]    in_entry_char    = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic                 out_char_valid;
  logic [CHAR_W-1:0]    out_char_out;
  logic                 out_queued;
  logic                 out_dropped;
  logic [LEVEL_W-1:0]   out_fifo_level;
  logic [PAT_W-1:0]     out_key_pattern;

  // model state
  logic [PAT_W-1:0]    held_pattern;
  logic [TIME_W-1:0]   repeat_due;
  logic [PAT_W-1:0]    map_pat [MAP_N];
  logic [CHAR_W-1:0]   map_chr [MAP_N];
  logic [CHAR_W-1:0]   char_fifo [$];
  logic [DELAY_W-1:0]  first_ticks;
  logic [DELAY_W-1:0]  repeat_ticks;
  logic [TCOUNT_W-1:0] search_count;
  key_result_t         pending_results [$];

  logic [TIME_W-1:0] now_ticks = '0;
  int                snd_idle_pct = 29;
  int                rcv_idle_pct = 78;
  int                pop_pct = 0;
  int                mismatches = 0;
  int unsigned       cycle_cnt = 0;

  keypad_scan_autorepeat_fifo_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_now           (in_now),
    .in_row0_cols     (in_row0_cols),
    .in_row1_cols     (in_row1_cols),
    .in_row2_cols     (in_row2_cols),
    .in_row3_cols     (in_row3_cols),
    .in_entry_index   (in_entry_index),
    .in_entry_pattern (in_entry_pattern),
    .in_entry_char    (in_entry_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_valid   (out_char_valid),
    .out_char_out     (out_char_out),
    .out_queued       (out_queued),
    .out_dropped      (out_dropped),
    .out_fifo_level   (out_fifo_level),
    .out_key_pattern  (out_key_pattern)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] map_lookup(input logic [PAT_W-1:0] keys);
    int lim;
    lim = (search_count > MAP_N) ? MAP_N : int'(search_count);
    for (int i = 0; i < lim; i++) begin
      if (map_pat[i] == keys) return map_chr[i];
    end
    return '0;
  endfunction

  function automatic key_result_t keypad_outcome(input key_item_t it);
    key_result_t       r;
    logic [PAT_W-1:0]  keys;
    logic [CHAR_W-1:0] ch;
    logic [TIME_W-1:0] lag;
    r = '0;
    ch = '0;
    keys = held_pattern;
    case (it.op)
      OP_SCAN: begin
        keys = ~({it.row0, it.row1, it.row2, it.row3} ^ 16'h8888);
        lag = it.now - repeat_due;
        if (keys != '0) begin
          if (keys != held_pattern) begin
            repeat_due = it.now + {1'b0, first_ticks};
            ch = map_lookup(keys);
          end else if (!lag[TIME_W-1]) begin
            repeat_due = it.now + {1'b0, repeat_ticks};
            ch = map_lookup(keys);
          end
        end
        held_pattern = keys;
        if (ch != '0) begin
          if (char_fifo.size() < FIFO_CAP) begin
            char_fifo.push_back(ch);
            r.queued = 1'b1;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (char_fifo.size() != 0) begin
          r.chv = 1'b1;
          r.chr = char_fifo.pop_front();
        end
      end
      OP_TABLE: begin
        map_pat[it.slot] = it.spat;
        map_chr[it.slot] = it.schr;
      end
      default: ;
    endcase
    r.level = LEVEL_W'(char_fifo.size());
    r.keys = keys;
    return r;
  endfunction

  // mostly held keys with advancing time, some releases, new presses and raw noise
  function automatic key_item_t random_key_item();
    key_item_t        it;
    logic [PAT_W-1:0] keys;
    int unsigned      pick;
    it.op = OP_SCAN;
    it.now = $urandom();
    it.row0 = NIB_W'($urandom_range(0, 15));
    it.row1 = NIB_W'($urandom_range(0, 15));
    it.row2 = NIB_W'($urandom_range(0, 15));
    it.row3 = NIB_W'($urandom_range(0, 15));
    it.slot = EIDX_W'($urandom_range(0, 31));
    it.spat = PAT_W'($urandom_range(0, 65535));
    it.schr = CHAR_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < pop_pct) begin
      it.op = OP_POP;
    end else if (pick < pop_pct + 8) begin
      it.op = OP_TABLE;
      if ($urandom_range(0, 1) == 0) it.spat = PAT_W'(1) << $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) it.schr = '0;
    end else if (pick < pop_pct + 10) begin
      it.op = OP_UNUSED;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) keys = '0;
      else if (pick < 20 || (pick < 75 && held_pattern == '0))
        keys = PAT_W'(1) << $urandom_range(0, 15);
      else if (pick < 28) keys = map_pat[$urandom_range(0, MAP_N - 1)];
      else keys = held_pattern;
      pick = $urandom_range(0, 99);
      if (pick < 80) now_ticks = now_ticks + $urandom_range(0, 12);
      else if (pick < 90) now_ticks = repeat_due + $urandom_range(0, 2) - 1;
      else if (pick < 97) now_ticks = now_ticks + $urandom_range(0, 300);
      else now_ticks = $urandom();
      it.now = now_ticks;
      if ($urandom_range(0, 19) != 0) {it.row0, it.row1, it.row2, it.row3} = keys ^ 16'h7777;
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  task automatic check_result();
    key_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("result beat with nothing pending", 32'd1, 32'd0);
      return;
    end
    want = pending_results.pop_front();
    if (out_char_valid !== want.chv) flag_mismatch("char_valid", out_char_valid, want.chv);
    if (out_char_out !== want.chr) flag_mismatch("char_out", out_char_out, want.chr);
    if (out_queued !== want.queued) flag_mismatch("queued", out_queued, want.queued);
    if (out_dropped !== want.dropped) flag_mismatch("dropped", out_dropped, want.dropped);
    if (out_fifo_level !== want.level) flag_mismatch("fifo_level", out_fifo_level, want.level);
    if (out_key_pattern !== want.keys) flag_mismatch("key_pattern", out_key_pattern, want.keys);
  endtask

  task automatic send_key_item(input key_item_t it, input logic use_fixed,
                               input key_result_t fixed);
    key_result_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= it.op;
    in_now           <= it.now;
    in_row0_cols     <= it.row0;
    in_row1_cols     <= it.row1;
    in_row2_cols     <= it.row2;
    in_row3_cols     <= it.row3;
    in_entry_index   <= it.slot;
    in_entry_pattern <= it.spat;
    in_entry_char    <= it.schr;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    want = keypad_outcome(it);
    pending_results.push_back(use_fixed ? fixed : want);
  endtask

  task automatic load_settings(input logic [DELAY_W-1:0] fd, input logic [DELAY_W-1:0] rd,
                               input logic [TCOUNT_W-1:0] tc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_DELAY;
    cfg_wdata <= fd;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_DELAY;
    cfg_wdata <= rd;
    @(posedge clk);
    cfg_index <= CFG_TABLE_COUNT;
    cfg_wdata <= CFG_W'(tc);
    @(posedge clk);
    cfg_we <= 1'b0;
    first_ticks = fd;
    repeat_ticks = rd;
    search_count = tc;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    key_item_t it;
    held_pattern = '0;
    repeat_due = '0;
    first_ticks = FIRST_DELAY_RST;
    repeat_ticks = REPEAT_DELAY_RST;
    search_count = TABLE_COUNT_RST;
    for (int i = 0; i < MAP_N; i++) begin
      map_pat[i] = '0;
      map_chr[i] = '0;
      if (i < 16) begin
        map_pat[i] = PAT_W'(1) << i;
        map_chr[i] = KEY_CHARS[i];
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      it.op = DIRECTED[r].op;
      it.now = DIRECTED[r].now;
      {it.row0, it.row1, it.row2, it.row3} = DIRECTED[r].keys ^ 16'h7777;
      it.slot = DIRECTED[r].slot;
      it.spat = DIRECTED[r].spat;
      it.schr = DIRECTED[r].schr;
      send_key_item(it, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // hold off until the block has drained before touching registers
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (p == 2) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 29;
      end else if (p == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      pop_pct = POP_PCT[p];
      load_settings(FD_SET[p], RD_SET[p], TC_SET[p]);
      repeat (PHASE_ITEMS) send_key_item(random_key_item(), 1'b0, QUIET);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kpsa_pkg.sv
rtl/keypad_scan_autorepeat_fifo_unit.sv
tb/sv/tb_keypad_scan_autorepeat_fifo_unit.sv
